>>> hdl/sptd_pkg.sv
`default_nettype none

package sptd_pkg;

	localparam int P_W     = 24;
	localparam int TARE_W  = 15;
	localparam int S_W     = 16;
	localparam int X_W     = 25;
	localparam int DEPTH_W = 25;
	localparam int NUM_W   = 62;
	localparam int G_W     = 36;
	localparam int QB      = 25;

	localparam logic [TARE_W-1:0] TARE_RST = 15'd10133;
	localparam logic [S_W-1:0]    SIN_RST  = 16'd0;

	// configuration register indexes
	localparam logic [0:0] REG_SIN_SQ = 1'b0;
	localparam logic [0:0] REG_TARE   = 1'b1;

	localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -25'sd20000;
	localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 25'sd12000000;

	// numerator and gravity, both at scale 2^-32, headed for the divider
	typedef struct packed {
		logic                    vld;
		logic signed [NUM_W-1:0] num;
		logic [G_W-1:0]          g;
	} div_req_t;

endpackage

`default_nettype wire

>>> hdl/sptd_poly.sv
`default_nettype none

module sptd_poly (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld_s1,
	input  logic signed [sptd_pkg::X_W-1:0]  x_s1,
	output logic                             vld_s6,
	output logic signed [sptd_pkg::NUM_W-1:0] num_s6
);

	localparam logic signed [19:0] B4 = -20'sd144195;
	localparam logic signed [45:0] B3 = 46'sd18056098237001;
	localparam logic signed [56:0] B2 = -57'sd27215338051164500;
	localparam logic signed [60:0] B1 = 61'sd700874643593369483;

	logic vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [sptd_pkg::X_W-1:0] x_s2, x_s3, x_s4;

	logic signed [45:0] r3_s2;
	logic signed [56:0] r2_s3;
	logic signed [60:0] r1_s4;
	logic signed [43:0] pp_hi_s5, pp_lo_s5;

	logic signed [44:0] p3;
	logic signed [54:0] p2;
	logic signed [57:0] p1;
	logic signed [29:0] r3_sh;
	logic signed [32:0] r2_sh;
	logic signed [18:0] r1_hi;
	logic signed [18:0] r1_lo;

	always_comb begin
		p3    = B4 * x_s1;
		r3_sh = r3_s2[45:16];
		p2    = r3_sh * x_s2;
		r2_sh = r2_s3[56:24];
		p1    = r2_sh * x_s3;
		// r1 >> 24 split into 19 + 18 bits to keep each product narrow
		r1_hi = r1_s4[60:42];
		r1_lo = {1'b0, r1_s4[41:24]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_s2     <= x_s1;
		x_s3     <= x_s2;
		x_s4     <= x_s3;
		r3_s2    <= B3 + 46'(p3);
		r2_s3    <= B2 + 57'(p2);
		r1_s4    <= B1 + 61'(p1);
		pp_hi_s5 <= r1_hi * x_s4;
		pp_lo_s5 <= r1_lo * x_s4;
		num_s6   <= (sptd_pkg::NUM_W'(pp_hi_s5) <<< 18) + sptd_pkg::NUM_W'(pp_lo_s5);
	end

endmodule

`default_nettype wire

>>> hdl/sptd_grav.sv
`default_nettype none

module sptd_grav (
	input  logic                            clk,
	input  logic signed [sptd_pkg::X_W-1:0] x_s1,
	input  logic [sptd_pkg::S_W-1:0]        s_s1,
	output logic [sptd_pkg::G_W-1:0]        g_s6
);

	localparam logic [32:0]        Q1 = 33'd6642809450;
	localparam logic [40:0]        Q0 = 41'd1485850107060;
	localparam logic [35:0]        G0 = 36'd42006145954;
	localparam logic signed [19:0] KP = 20'sd307371;

	logic [sptd_pkg::S_W-1:0] s_s2, s_s3;
	logic [48:0]        qm_s2;
	logic [40:0]        q_s3;
	logic [24:0]        fh_s4;
	logic [28:0]        gm_s5;
	logic signed [28:0] kp_s2, kp_s3, kp_s4, kp_s5;

	logic signed [44:0] kpx;
	logic [56:0]        fp;
	logic [60:0]        gp;
	logic signed [36:0] gsum;

	always_comb begin
		kpx  = KP * x_s1;
		fp   = q_s3 * s_s3;
		gp   = G0 * fh_s4;
		gsum = $signed({1'b0, G0}) + $signed({8'b0, gm_s5}) + 37'(kp_s5);
	end

	always_ff @(posedge clk) begin
		s_s2  <= s_s1;
		s_s3  <= s_s2;
		qm_s2 <= Q1 * s_s1;
		kp_s2 <= kpx[44:16];
		kp_s3 <= kp_s2;
		kp_s4 <= kp_s3;
		kp_s5 <= kp_s4;
		q_s3  <= Q0 + 41'(qm_s2[48:16]);
		// keep f >> 16 only
		fh_s4 <= fp[56:32];
		gm_s5 <= gp[60:32];
		// always positive: the latitude term dominates any tare underflow
		g_s6  <= gsum[sptd_pkg::G_W-1:0];
	end

endmodule

`default_nettype wire

>>> hdl/sptd_div.sv
`default_nettype none

module sptd_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sptd_pkg::div_req_t                   req,
	output logic                                 done,
	output logic signed [sptd_pkg::DEPTH_W-1:0]  depth_mm
);

	localparam int QB  = sptd_pkg::QB;
	localparam int G_W = sptd_pkg::G_W;
	localparam int DW  = sptd_pkg::DEPTH_W;
	localparam logic [QB-1:0] NEG_LIM = QB'(-sptd_pkg::DEPTH_MIN);
	localparam logic [QB-1:0] POS_LIM = QB'(sptd_pkg::DEPTH_MAX);

	logic          vld_s  [QB+1];
	logic          neg_s  [QB+1];
	logic [QB-1:0] bits_s [QB+1];
	logic [G_W-1:0] rem_s [QB];
	logic [G_W-1:0] g_s   [QB];

	logic [sptd_pkg::NUM_W-1:0] mag;
	logic [QB-1:0]              quo;
	logic signed [DW-1:0]       res;

	assign mag = req.num[sptd_pkg::NUM_W-1] ? sptd_pkg::NUM_W'(-req.num)
	                                        : sptd_pkg::NUM_W'(req.num);

	// entry: upper dividend bits are already below g, the low QB bits shift in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0]  <= req.num[sptd_pkg::NUM_W-1];
		rem_s[0]  <= mag[G_W+QB-1:QB];
		bits_s[0] <= mag[QB-1:0];
		g_s[0]    <= req.g;
	end

	// one restoring step per stage; bits_s holds dividend bits above, quotient below
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [G_W:0] trial;
		logic [G_W:0] diff;
		logic         take;

		always_comb begin
			trial = {rem_s[k], bits_s[k][QB-1]};
			diff  = trial - {1'b0, g_s[k]};
			take  = !diff[G_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[k+1]  <= neg_s[k];
			bits_s[k+1] <= {bits_s[k][QB-2:0], take};
		end

		if (k < QB-1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? diff[G_W-1:0] : trial[G_W-1:0];
				g_s[k+1]   <= g_s[k];
			end
		end
	end

	assign quo = bits_s[QB];

	always_comb begin
		if (neg_s[QB]) begin
			if (quo > NEG_LIM) begin
				res = sptd_pkg::DEPTH_MIN;
			end else begin
				res = -$signed(DW'(quo));
			end
		end else begin
			if (quo > POS_LIM) begin
				res = sptd_pkg::DEPTH_MAX;
			end else begin
				res = $signed(DW'(quo));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		depth_mm <= res;
	end

`ifndef SYNTHESIS
	a_rem_entry: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> (rem_s[0] < g_s[0]))
		else $error("divider entry remainder not below divisor");
	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB-1] |-> (rem_s[QB-1] < g_s[QB-1]))
		else $error("divider remainder escaped divisor range");
`endif

endmodule

`default_nettype wire

>>> hdl/seawater_pressure_to_depth_core.sv
// Pressure (mdbar) to seawater depth (mm), fully pipelined, no backpressure.
// Path: start and pressure are registered, then pass the polynomial and gravity
// stages, the divider entry register, the divider steps and the output register.
// Throughput: one sample per clock; every stage, the 25-step restoring divider
// included, takes a new beat each cycle, so busy stays low.
// Reset (arst_n low): valid chain cleared, sin_sq_latitude = 0, tare_mdbar = 10133.
`default_nettype none

module seawater_pressure_to_depth_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sptd_pkg::P_W-1:0]             pressure_mdbar,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [sptd_pkg::S_W-1:0]             cfg_wdata,
	output logic                                 done,
	output logic signed [sptd_pkg::DEPTH_W-1:0]  depth_mm
);

	localparam int         PAD_W      = sptd_pkg::X_W - sptd_pkg::TARE_W;

	logic [sptd_pkg::S_W-1:0]    sin_sq_q;
	logic [sptd_pkg::TARE_W-1:0] tare_q;

	logic                            vld_s1;
	logic signed [sptd_pkg::X_W-1:0] x_s1;
	logic [sptd_pkg::S_W-1:0]        sin_sq_s1;

	logic                                vld_s6;
	logic signed [sptd_pkg::NUM_W-1:0]   num_s6;
	logic [sptd_pkg::G_W-1:0]            g_s6;
	sptd_pkg::div_req_t                  div_req;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_sq_q <= sptd_pkg::SIN_RST;
			tare_q   <= sptd_pkg::TARE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sptd_pkg::REG_SIN_SQ: sin_sq_q <= cfg_wdata;
				sptd_pkg::REG_TARE:   tare_q   <= cfg_wdata[sptd_pkg::TARE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	// gauge pressure, signed: below tare gives a negative depth
	always_ff @(posedge clk) begin
		x_s1      <= $signed({1'b0, pressure_mdbar}) - $signed({{PAD_W{1'b0}}, tare_q});
		sin_sq_s1 <= sin_sq_q;
	end

	sptd_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.x_s1   (x_s1),
		.vld_s6 (vld_s6),
		.num_s6 (num_s6)
	);

	sptd_grav u_grav (
		.clk  (clk),
		.x_s1 (x_s1),
		.s_s1 (sin_sq_s1),
		.g_s6 (g_s6)
	);

	assign div_req = '{vld: vld_s6, num: num_s6, g: g_s6};

	sptd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (done),
		.depth_mm (depth_mm)
	);

`ifndef SYNTHESIS
	localparam int LAT = 33;
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted sample produced no result");
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted sample");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (depth_mm >= sptd_pkg::DEPTH_MIN && depth_mm <= sptd_pkg::DEPTH_MAX))
		else $error("depth outside saturation limits");
`endif

endmodule

`default_nettype wire

>>> test/seawater_pressure_to_depth_core_tb.sv
`default_nettype none

module seawater_pressure_to_depth_core_tb;

	localparam int WATCHDOG   = 2000;
	localparam int TAIL_WAIT  = 40;
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 158;
	localparam int N_DIR      = 20;

	// polynomial in mm per mdbar
	localparam longint POLY_B4 = -64'sd144195;
	localparam longint POLY_B3 = 64'sd18056098237001;
	localparam longint POLY_B2 = -64'sd27215338051164500;
	localparam longint POLY_B1 = 64'sd700874643593369483;
	// gravity terms
	localparam longint unsigned GRAV_Q0 = 64'd1485850107060;
	localparam longint unsigned GRAV_Q1 = 64'd6642809450;
	localparam longint unsigned GRAV_G0 = 64'd42006145954;
	localparam longint          GRAV_KP = 64'sd307371;

	typedef struct packed {
		logic                                wr;
		logic [sptd_pkg::S_W-1:0]            sin_wd;
		logic [sptd_pkg::S_W-1:0]            tare_wd;
		logic [sptd_pkg::P_W-1:0]            p;
		logic                                fixed;
		logic signed [sptd_pkg::DEPTH_W-1:0] depth;
	} dir_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [sptd_pkg::P_W-1:0]            pressure_mdbar;
	logic                                cfg_we;
	logic [0:0]                          cfg_index;
	logic [sptd_pkg::S_W-1:0]            cfg_wdata;
	logic                                done;
	logic signed [sptd_pkg::DEPTH_W-1:0] depth_mm;

	logic signed [sptd_pkg::DEPTH_W-1:0] pending_depth[$];
	logic [sptd_pkg::S_W-1:0]            sin_cur;
	logic [sptd_pkg::TARE_W-1:0]         tare_cur;
	logic signed [sptd_pkg::DEPTH_W-1:0] want;
	int                                  fails = 0;
	int                                  quiet_cycles = 0;

	// rows with a typed depth are the ones readable at a glance: zero gauge
	// pressure and the two saturation limits
	dir_row_t dir_tbl [N_DIR] = '{
		'{1'b0, 16'h0000, 16'h0000, 24'd10133,    1'b1, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd0,        1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd12000000, 1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'hFFFFFF,   1'b1, sptd_pkg::DEPTH_MAX},
		'{1'b1, 16'hFFFF, 16'h0000, 24'd0,        1'b1, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd1,        1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd12000000, 1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'hFFFFFF,   1'b1, sptd_pkg::DEPTH_MAX},
		'{1'b0, 16'h0000, 16'h0000, 24'h555555,   1'b0, 25'sd0},
		'{1'b1, 16'h0000, 16'hFFFF, 24'd0,        1'b1, sptd_pkg::DEPTH_MIN},
		'{1'b0, 16'h0000, 16'h0000, 24'd32767,    1'b1, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'hAAAAAA,   1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd12345,    1'b0, 25'sd0},
		'{1'b1, 16'h8000, 16'd20000, 24'd20000,   1'b1, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd19999,    1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd20001,    1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd11000000, 1'b0, 25'sd0},
		'{1'b1, 16'd12345, 16'd10133, 24'd4000000, 1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd10132,    1'b0, 25'sd0},
		'{1'b0, 16'h0000, 16'h0000, 24'd7654321,  1'b0, 25'sd0}
	};

	seawater_pressure_to_depth_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.pressure_mdbar (pressure_mdbar),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.depth_mm       (depth_mm)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [sptd_pkg::DEPTH_W-1:0] depth_of(
			input logic [sptd_pkg::P_W-1:0] p,
			input logic [sptd_pkg::S_W-1:0] s_q16,
			input logic [sptd_pkg::TARE_W-1:0] tare);
		longint          x, r3, r2, r1, num, kx, g, d;
		longint unsigned s, q, f, glat;
		x   = longint'({40'd0, p}) - longint'({49'd0, tare});
		r3  = POLY_B3 + POLY_B4 * x;
		r2  = POLY_B2 + (r3 >>> 16) * x;
		r1  = POLY_B1 + (r2 >>> 24) * x;
		num = (r1 >>> 24) * x;
		s    = {48'd0, s_q16};
		q    = GRAV_Q0 + ((GRAV_Q1 * s) >> 16);
		f    = (q * s) >> 16;
		glat = GRAV_G0 + ((GRAV_G0 * (f >> 16)) >> 32);
		// pressure term kept apart so the shift stays arithmetic
		kx = (GRAV_KP * x) >>> 16;
		g  = longint'(glat) + kx;
		d  = num / g;
		if (d < longint'(sptd_pkg::DEPTH_MIN))
			d = longint'(sptd_pkg::DEPTH_MIN);
		if (d > longint'(sptd_pkg::DEPTH_MAX))
			d = longint'(sptd_pkg::DEPTH_MAX);
		return d[sptd_pkg::DEPTH_W-1:0];
	endfunction

	function automatic logic [sptd_pkg::P_W-1:0] pick_pressure(
			input logic [sptd_pkg::TARE_W-1:0] tare);
		int          sel;
		int unsigned lo, hi;
		sel = $urandom_range(0, 9);
		case (sel)
			5: begin
				return sptd_pkg::P_W'($urandom());
			end
			6: begin
				// around zero gauge pressure
				lo = (tare > 2000) ? tare - 2000 : 0;
				hi = tare + 2000;
				return sptd_pkg::P_W'($urandom_range(hi, lo));
			end
			7: begin
				return sptd_pkg::P_W'($urandom_range(24'hFFFFFF, 11500000));
			end
			8: begin
				return sptd_pkg::P_W'($urandom_range(40000, 0));
			end
			9: begin
				return $urandom_range(1, 0) ? 24'hFFFFFF : 24'd0;
			end
			default: begin
				return sptd_pkg::P_W'($urandom_range(12000000, 0));
			end
		endcase
	endfunction

	task automatic write_reg(input logic [0:0] idx, input logic [sptd_pkg::S_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == sptd_pkg::REG_SIN_SQ)
			sin_cur = val;
		else
			tare_cur = val[sptd_pkg::TARE_W-1:0];
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_depth.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(input logic [sptd_pkg::S_W-1:0] sin_wd,
			input logic [sptd_pkg::S_W-1:0] tare_wd);
		settle();
		write_reg(sptd_pkg::REG_SIN_SQ, sin_wd);
		write_reg(sptd_pkg::REG_TARE, tare_wd);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one beat; the expectation is queued at the edge that takes it
	task automatic send(input logic [sptd_pkg::P_W-1:0] p, input logic use_fixed,
			input logic signed [sptd_pkg::DEPTH_W-1:0] fixed_depth);
		@(negedge clk);
		start          <= 1'b1;
		pressure_mdbar <= p;
		do
			@(posedge clk);
		while (busy);
		if (use_fixed)
			pending_depth.push_back(fixed_depth);
		else
			pending_depth.push_back(depth_of(p, sin_cur, tare_cur));
	endtask

	task automatic run_bursts(input int n_items, input int drain_at);
		int left;
		int i;
		left = 0;
		for (i = 0; i < n_items; i++) begin
			if (i == drain_at)
				settle();
			if (left == 0) begin
				if (i != 0) begin
					@(negedge clk);
					start <= 1'b0;
					repeat ($urandom_range(6, 0))
						@(negedge clk);
				end
				left = $urandom_range(1, 2) == 1 ? $urandom_range(40, 10) : $urandom_range(6, 1);
			end
			send(pick_pressure(tare_cur), 1'b0, '0);
			left--;
		end
		@(negedge clk);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("[FAIL] regression broken");
				$finish;
			end
			if (done) begin
				if (pending_depth.size() == 0) begin
					$error("depth_mm: nothing expected, got %0d", depth_mm);
					fails++;
				end else begin
					want = pending_depth.pop_front();
					if (depth_mm !== want) begin
						$error("depth_mm: expected %0d, got %0d", want, depth_mm);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		logic [sptd_pkg::S_W-1:0] sin_wd;
		logic [sptd_pkg::S_W-1:0] tare_wd;
		int                       ph;
		int                       k;
		arst_n         = 1'b0;
		start          = 1'b0;
		pressure_mdbar = '0;
		cfg_we         = 1'b0;
		cfg_index      = sptd_pkg::REG_SIN_SQ;
		cfg_wdata      = '0;
		sin_cur        = sptd_pkg::SIN_RST;
		tare_cur       = sptd_pkg::TARE_RST;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < N_DIR; k++) begin
			if (dir_tbl[k].wr)
				load_config(dir_tbl[k].sin_wd, dir_tbl[k].tare_wd);
			send(dir_tbl[k].p, dir_tbl[k].fixed, dir_tbl[k].depth);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					sin_wd  = 16'hFFFF;
					tare_wd = 16'd0;
				end
				1: begin
					sin_wd  = 16'h0000;
					tare_wd = 16'd20000;
				end
				2: begin
					// tare past its nominal range, upper wdata bit dropped
					sin_wd  = sptd_pkg::S_W'($urandom());
					tare_wd = sptd_pkg::S_W'($urandom_range(16'hFFFF, 16'd20001));
				end
				default: begin
					sin_wd  = sptd_pkg::S_W'($urandom());
					tare_wd = sptd_pkg::S_W'($urandom_range(20000, 0));
				end
			endcase
			load_config(sin_wd, tare_wd);
			run_bursts(PHASE_LEN, (ph == 3) ? PHASE_LEN / 2 : -1);
		end

		settle();
		repeat (TAIL_WAIT)
			@(posedge clk);
		if (fails == 0 && pending_depth.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hdl/sptd_pkg.sv
hdl/sptd_poly.sv
hdl/sptd_grav.sv
hdl/sptd_div.sv
hdl/seawater_pressure_to_depth_core.sv
test/seawater_pressure_to_depth_core_tb.sv
